/* design/btc_pkg.sv */
// Shared types, constants and a helper function for the block transposition cipher.
package btc_pkg;

  localparam int unsigned MAX_BLOCK = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_BLOCK);
  localparam int unsigned LEN_W     = IDX_W + 1;
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned KEYMAP_W  = 64;

  localparam logic [7:0] PAD_BYTE = 8'h20;

  // Configuration register indexes.
  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
  localparam logic [1:0] REG_KEY_MAP      = 2'd1;
  localparam logic [1:0] REG_DIRECTION    = 2'd2;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAT_RD = 5'b00010,
    ST_SCAT_WR = 5'b00100,
    ST_EMIT_RD = 5'b01000,
    ST_EMIT_WR = 5'b10000
  } state_t;

  // Zero acts as one, anything above the buffer size acts as the buffer size.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > LEN_W'(MAX_BLOCK)) begin
      res = LEN_W'(MAX_BLOCK);
    end
    return res;
  endfunction

endpackage

/* design/btc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module btc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/block_transposition_cipher_top.sv */
// Block transposition cipher: gathers message bytes into blocks and emits them permuted.
// Bytes are taken one per cycle while the block fills. The byte that fills the block, or that
// carries the message-end mark, starts the permutation and the input stays not ready until the last
// byte of that block has been loaded into the output register. Each position passes through a
// read state and a write state. In encrypt mode emission reads the block buffer at the key
// position; in decrypt mode a scatter pass from the block buffer into a result buffer comes
// first, and emission then reads the result buffer. Stalls on the output hold the emit state.
module block_transposition_cipher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_block_end,
  output logic        out_message_end
);

  localparam int unsigned IDX_W = btc_pkg::IDX_W;
  localparam int unsigned LEN_W = btc_pkg::LEN_W;

  btc_pkg::state_t state;

  logic [LEN_W-1:0]              block_length;
  logic [btc_pkg::KEYMAP_W-1:0]  key_map;
  logic                          direction;

  logic [LEN_W-1:0]              fill;
  logic [IDX_W-1:0]              idx;
  logic                          msg_end;
  logic [btc_pkg::MAX_BLOCK-1:0] res_mask;

  logic [LEN_W-1:0]         len;
  logic [btc_pkg::KEY_W-1:0] key_k;
  logic                     key_in_block;
  logic                     last;
  logic                     in_fire;
  logic                     out_free;
  logic [LEN_W-1:0]         fill_next;
  logic                     close_block;

  logic                     buf_we;
  logic                     buf_re;
  logic [IDX_W-1:0]         buf_raddr;
  logic [7:0]               buf_rdata;
  logic                     res_we;
  logic                     res_re;
  logic [7:0]               res_rdata;
  logic [7:0]               scat_byte;
  logic [7:0]               emit_byte;

  assign len          = btc_pkg::eff_len(block_length);
  assign key_k        = key_map[{idx, 2'b00} +: btc_pkg::KEY_W];
  assign key_in_block = {1'b0, key_k} < len;
  assign last         = {1'b0, idx} == (len - LEN_W'(1));

  assign in_ready    = (state == btc_pkg::ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;

  assign fill_next   = fill[LEN_W-1] ? fill : fill + LEN_W'(1);
  assign close_block = (fill_next >= len) || in_message_end;

  assign buf_we    = in_fire && !fill[LEN_W-1];
  assign buf_re    = (state == btc_pkg::ST_SCAT_RD) || (state == btc_pkg::ST_EMIT_RD);
  assign buf_raddr = (state == btc_pkg::ST_SCAT_RD) ? idx : key_k;

  assign res_we = (state == btc_pkg::ST_SCAT_WR) && key_in_block;
  assign res_re = (state == btc_pkg::ST_EMIT_RD);

  // Positions past the stored fill are padding.
  assign scat_byte = ({1'b0, idx} < fill) ? buf_rdata : btc_pkg::PAD_BYTE;

  always_comb begin
    if (direction == btc_pkg::DIR_DECRYPT) begin
      emit_byte = res_mask[idx] ? res_rdata : btc_pkg::PAD_BYTE;
    end else begin
      emit_byte = (key_in_block && ({1'b0, key_k} < fill)) ? buf_rdata : btc_pkg::PAD_BYTE;
    end
  end

  btc_ram #(.WIDTH(8), .DEPTH(btc_pkg::MAX_BLOCK)) u_block_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (fill[IDX_W-1:0]),
    .wdata (in_byte),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  btc_ram #(.WIDTH(8), .DEPTH(btc_pkg::MAX_BLOCK)) u_result_buf (
    .clk   (clk),
    .we    (res_we),
    .waddr (key_k),
    .wdata (scat_byte),
    .re    (res_re),
    .raddr (idx),
    .rdata (res_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= LEN_W'(btc_pkg::MAX_BLOCK);
      key_map      <= '0;
      direction    <= btc_pkg::DIR_ENCRYPT;
    end else if (cfg_write) begin
      case (cfg_index)
        btc_pkg::REG_BLOCK_LENGTH: block_length <= cfg_data[LEN_W-1:0];
        btc_pkg::REG_KEY_MAP:      key_map      <= cfg_data;
        btc_pkg::REG_DIRECTION:    direction    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= btc_pkg::ST_IDLE;
      fill      <= '0;
      idx       <= '0;
      msg_end   <= 1'b0;
      res_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      // The emit state reloads the output register itself when it is free.
      if (out_valid && out_ready && (state != btc_pkg::ST_EMIT_WR)) begin
        out_valid <= 1'b0;
      end
      case (state)
        btc_pkg::ST_IDLE: begin
          if (in_fire) begin
            fill     <= fill_next;
            msg_end  <= in_message_end;
            idx      <= '0;
            res_mask <= '0;
            if (close_block) begin
              state <= (direction == btc_pkg::DIR_DECRYPT) ? btc_pkg::ST_SCAT_RD
                                                           : btc_pkg::ST_EMIT_RD;
            end
          end
        end
        btc_pkg::ST_SCAT_RD: begin
          state <= btc_pkg::ST_SCAT_WR;
        end
        btc_pkg::ST_SCAT_WR: begin
          // A later key entry naming the same position overwrites the earlier one.
          if (key_in_block) begin
            res_mask[key_k] <= 1'b1;
          end
          if (last) begin
            idx   <= '0;
            state <= btc_pkg::ST_EMIT_RD;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= btc_pkg::ST_SCAT_RD;
          end
        end
        btc_pkg::ST_EMIT_RD: begin
          state <= btc_pkg::ST_EMIT_WR;
        end
        btc_pkg::ST_EMIT_WR: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_byte        <= emit_byte;
            out_block_end   <= last;
            out_message_end <= last && msg_end;
            if (last) begin
              fill  <= '0;
              idx   <= '0;
              state <= btc_pkg::ST_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= btc_pkg::ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= btc_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/btc_checker.sv */
// Port-level assertions for the block transposition cipher, bound to the top level.
module btc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_message_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_block_end,
  input logic        out_message_end
);

  // A waiting result transaction keeps its byte.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output byte changed while stalled");

  // The message-end mark always closes a block, so input stops for emission.
  a_msg_end_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_message_end |=> !in_ready)
    else $error("input still ready after message end");

  a_msg_end_is_block_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_message_end |-> out_block_end)
    else $error("message end without block end");

  // While a block is still being emitted the input side stays closed.
  a_block_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_block_end |-> !in_ready)
    else $error("input ready in the middle of a block");

endmodule

bind block_transposition_cipher_top btc_checker u_btc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_message_end  (in_message_end),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_block_end   (out_block_end),
  .out_message_end (out_message_end)
);
